>>> hdl/lbsf_pkg.sv
// Shared constants, types and state encodings of the log packet framer.
package lbsf_pkg;

  // Payload and header geometry.
  localparam int unsigned MAX_PAYLOAD_BYTES = 8;
  localparam int unsigned HDR_BYTES = 7;
  localparam int unsigned HDR_W = 8 * HDR_BYTES;
  localparam int unsigned HDR_CNT_W = $clog2(HDR_BYTES);
  localparam int unsigned LEN_W = 4;

  // Byte queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Stuffing constants.
  localparam logic [7:0] FLAG_BYTE   = 8'h7e;
  localparam logic [7:0] ESC_BYTE    = 8'h7d;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] START_RESET = 8'h7e;

  // Buffer fill count saturates at this value.
  localparam int unsigned FILL_W = 9;
  localparam logic [FILL_W-1:0] FILL_LIMIT = 9'd256;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HDR,
    F_PAY
  } front_state_e;

  // One raw byte handed from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       raw;      // Sent as is, never escaped.
    logic       restart;  // Clear the fill count before this byte.
    logic       last;     // Final byte of the packet.
  } tok_t;

endpackage

>>> hdl/lbsf_front.sv
// Front part: accepts a packet and splits it into raw bytes in frame order.
module lbsf_front import lbsf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 new_buffer_i,
  input  logic [31:0]          stamp_ms_i,
  input  logic [15:0]          channel_id_i,
  input  logic [63:0]          payload_i,
  input  logic [LEN_W-1:0]     payload_len_i,
  input  logic [7:0]           start_byte_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output tok_t                 tok_o
);

  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD_BYTES);

  front_state_e         state_q, state_d;
  logic [HDR_W-1:0]     hdr_q, hdr_d;
  logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [63:0]          pay_q, pay_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic                 restart_q, restart_d;
  logic                 accept;
  logic [LEN_W-1:0]     len_eff;
  logic [2:0]           pay_idx;

  assign accept  = (state_q == F_IDLE) && in_valid_i;
  assign len_eff = (payload_len_i > LEN_MAX) ? LEN_MAX : payload_len_i;
  assign pay_idx = 3'(rem_q - LEN_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_HDR;
      end
      F_HDR: begin
        if (push_o && (hdr_cnt_q == HDR_LAST)) begin
          state_d = (rem_q == '0) ? F_IDLE : F_PAY;
        end
      end
      F_PAY: begin
        if (push_o && (rem_q == LEN_W'(1))) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs: the byte offered to the queue.
  always_comb begin
    in_stall_o    = (state_q != F_IDLE);
    push_o        = (state_q != F_IDLE) && !fifo_full_i;
    tok_o.data    = (state_q == F_PAY) ? pay_q[{pay_idx, 3'b000} +: 8] : hdr_q[HDR_W-1 -: 8];
    tok_o.raw     = (state_q == F_HDR) && (hdr_cnt_q == '0);
    tok_o.restart = restart_q;
    tok_o.last    = ((state_q == F_HDR) && (hdr_cnt_q == HDR_LAST) && (rem_q == '0)) ||
                    ((state_q == F_PAY) && (rem_q == LEN_W'(1)));
  end

  // Packet holding registers: load on accept, step on each push.
  always_comb begin
    hdr_d     = hdr_q;
    hdr_cnt_d = hdr_cnt_q;
    pay_d     = pay_q;
    rem_d     = rem_q;
    restart_d = restart_q;
    if (accept) begin
      hdr_d     = {start_byte_i, stamp_ms_i, channel_id_i};
      hdr_cnt_d = '0;
      pay_d     = payload_i;
      rem_d     = len_eff;
      restart_d = new_buffer_i;
    end else if (push_o) begin
      restart_d = 1'b0;
      if (state_q == F_HDR) begin
        hdr_d     = {hdr_q[HDR_W-9:0], 8'h00};
        hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
      end else begin
        rem_d = rem_q - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q     <= hdr_d;
    hdr_cnt_q <= hdr_cnt_d;
    pay_q     <= pay_d;
    rem_q     <= rem_d;
    restart_q <= restart_d;
  end

endmodule

>>> hdl/lbsf_fifo.sv
// Short byte queue that decouples the front from the back.
module lbsf_fifo import lbsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tok_t tok_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output tok_t tok_o
);

  tok_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign tok_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= tok_i;
  end

endmodule

>>> hdl/lbsf_back.sv
// Back part: escapes bytes, tracks the buffer position and drives the output word.
module lbsf_back import lbsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fifo_valid_i,
  input  tok_t       tok_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [7:0] byte_index_o,
  output logic       overflow_o,
  output logic       last_o
);

  logic              valid_q, valid_d;
  logic              esc_q, esc_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [7:0]        byte_q, byte_d;
  logic [7:0]        index_q, index_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic              can_load, emit, needs_esc;
  logic [FILL_W-1:0] base;

  assign can_load  = !valid_q || !out_stall_i;
  assign emit      = can_load && fifo_valid_i;
  assign needs_esc = !tok_i.raw && ((tok_i.data == FLAG_BYTE) || (tok_i.data == ESC_BYTE));
  // Position of the byte that goes out now.
  assign base      = tok_i.restart ? '0 : fill_q;

  // Escape sequencing and position bookkeeping.
  always_comb begin
    valid_d = valid_q;
    esc_d   = esc_q;
    fill_d  = fill_q;
    byte_d  = byte_q;
    index_d = index_q;
    ovf_d   = ovf_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (emit) begin
      valid_d = 1'b1;
      ovf_d   = base[FILL_W-1];
      index_d = base[FILL_W-1] ? 8'hff : base[7:0];
      fill_d  = base[FILL_W-1] ? FILL_LIMIT : base + FILL_W'(1);
      if (needs_esc && !esc_q) begin
        byte_d = ESC_BYTE;
        last_d = 1'b0;
        esc_d  = 1'b1;
      end else begin
        byte_d = esc_q ? (tok_i.data ^ ESC_XOR) : tok_i.data;
        last_d = tok_i.last;
        esc_d  = 1'b0;
        pop_o  = 1'b1;
      end
    end else if (can_load) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      esc_q   <= 1'b0;
      fill_q  <= '0;
    end else begin
      valid_q <= valid_d;
      esc_q   <= esc_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    index_q <= index_d;
    ovf_q   <= ovf_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign byte_index_o = index_q;
  assign overflow_o   = ovf_q;
  assign last_o       = last_q;

endmodule

>>> hdl/logger_packet_byte_stuffing_framer.sv
// Top level of the log packet framer with byte stuffing.
// A packet (start byte, four timestamp bytes, two id bytes and up to eight
// payload bytes, highest index first) leaves as one output word per cycle
// while the output is not stalled, an escaped byte taking two words, so 7 to
// 29 words in all. The front walks the packet one raw byte per cycle, while
// the queue is not full, into a four-entry queue and takes the next packet
// once it has queued the last byte, not while one is still being walked; the
// back has a single output register. The buffer position saturates at 256
// and reports overflow with index 255 until new_buffer clears it. The start
// byte register resets to 0x7e and must be written only while no packet is in
// flight.
module logger_packet_byte_stuffing_framer import lbsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration write channel.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_data_i,
  // Packet input channel.
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             new_buffer_i,
  input  logic [31:0]      stamp_ms_i,
  input  logic [15:0]      channel_id_i,
  input  logic [63:0]      payload_i,
  input  logic [LEN_W-1:0] payload_len_i,
  // Byte output channel.
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [7:0]       byte_index_o,
  output logic             overflow_o,
  output logic             last_o
);

  logic [7:0] start_q;
  logic       push, fifo_full, fifo_valid, pop;
  tok_t       front_tok, back_tok;

  // Start byte register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      start_q <= cfg_data_i;
    end
  end

  lbsf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .new_buffer_i  (new_buffer_i),
    .stamp_ms_i    (stamp_ms_i),
    .channel_id_i  (channel_id_i),
    .payload_i     (payload_i),
    .payload_len_i (payload_len_i),
    .start_byte_i  (start_q),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .tok_o         (front_tok)
  );

  lbsf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (front_tok),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .tok_o   (back_tok)
  );

  lbsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .tok_i        (back_tok),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_index_o (byte_index_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  // The front never offers a byte to a full queue.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("byte pushed into full queue");

  // An accepted packet keeps the input stalled until it has been walked.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after packet accept");

  // An overflowed position always reads as the top index.
  a_overflow_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (byte_index_o == 8'hff))
    else $error("overflow word without saturated index");
`endif

endmodule

>>> tb/logger_packet_byte_stuffing_framer_test.sv
// Self-checking testbench of the log packet framer with byte stuffing.
module logger_packet_byte_stuffing_framer_test;
  import lbsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles in which no channel moves anything before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 60;
  localparam int NUM_PHASES = 7;
  localparam int MAX_REPORTS = 40;

  // One packet as driven on the input channel, with optional typed bytes.
  typedef struct packed {
    logic              nb;
    logic [31:0]       stamp;
    logic [15:0]       chan;
    logic [63:0]       data;
    logic [LEN_W-1:0]  len;
    logic [4:0]        n_typed;
    logic [119:0]      typed;   // First typed byte in the top bits.
  } packet_row_t;

  // One output word as it should leave the block.
  typedef struct packed {
    logic [7:0] byte_val;
    logic [7:0] pos;
    logic       ovf;
    logic       last_flag;
  } framed_word_t;

  localparam int NUM_ROWS = 24;

  // Directed packets. Rows with typed bytes start a new buffer, so their
  // positions count up from zero with no overflow.
  localparam packet_row_t DIRECTED [NUM_ROWS] = '{
    // All zero right after reset.
    '{1'b1, 32'h0, 16'h0, 64'h0, 4'd0, 5'd7, {56'h7e000000000000, 64'h0}},
    // All ones with a full payload.
    '{1'b1, 32'hffff_ffff, 16'hffff, 64'hffff_ffff_ffff_ffff, 4'd8, 5'd15,
      {8'h7e, {14{8'hff}}}},
    // Every timestamp and id byte needs escaping.
    '{1'b1, 32'h7e7d_7e7d, 16'h7d7e, 64'h0, 4'd0, 5'd13,
      {104'h7e_7d5e_7d5d_7d5e_7d5d_7d5d_7d5e, 16'h0}},
    '{1'b0, 32'h1234_5678, 16'habcd, 64'h0011_2233_4455_6677, 4'd1, 5'd0, 120'h0},
    '{1'b0, 32'h0000_0001, 16'h0100, 64'h7d7e_0000_7e7d_7e7d, 4'd8, 5'd0, 120'h0},
    '{1'b0, 32'h0100_0080, 16'h8001, 64'h8040_2010_0804_0201, 4'd3, 5'd0, 120'h0},
    '{1'b0, 32'h5e5d_7c7f, 16'h7f7c, 64'h0102_0304_0506_077e, 4'd2, 5'd0, 120'h0},
    '{1'b0, 32'hdead_beef, 16'h55aa, 64'h7e7e_7e7e_7e7e_7e7e, 4'd4, 5'd0, 120'h0},
    '{1'b0, 32'h8000_0000, 16'h0001, 64'haaaa_5555_7d00_ff7d, 4'd5, 5'd0, 120'h0},
    '{1'b0, 32'h0f0f_f0f0, 16'hc3c3, 64'h1122_7d44_5566_7e88, 4'd6, 5'd0, 120'h0},
    '{1'b0, 32'h7e00_007d, 16'h0000, 64'h0123_4567_89ab_cdef, 4'd7, 5'd0, 120'h0},
    // Overlong lengths clamp to a full payload.
    '{1'b0, 32'h0000_ffff, 16'hff00, 64'h7e01_7d02_0304_0506, 4'd9, 5'd0, 120'h0},
    '{1'b0, 32'hffff_0000, 16'h00ff, 64'hfedc_ba98_7654_3210, 4'd15, 5'd0, 120'h0},
    // Fresh buffer, then maximum-size packets until the buffer overflows.
    '{1'b1, 32'h5d5e_7c7f, 16'h7f7c, 64'h0, 4'd0, 5'd0, 120'h0},
    '{1'b0, 32'h7e7e_7e7e, 16'h7e7e, {8{8'h7d}}, 4'd8, 5'd0, 120'h0},
    '{1'b0, 32'h7e7e_7e7e, 16'h7e7e, {8{8'h7d}}, 4'd8, 5'd0, 120'h0},
    '{1'b0, 32'h7e7e_7e7e, 16'h7e7e, {8{8'h7d}}, 4'd8, 5'd0, 120'h0},
    '{1'b0, 32'h7e7e_7e7e, 16'h7e7e, {8{8'h7d}}, 4'd8, 5'd0, 120'h0},
    '{1'b0, 32'h7e7e_7e7e, 16'h7e7e, {8{8'h7d}}, 4'd8, 5'd0, 120'h0},
    '{1'b0, 32'h7e7e_7e7e, 16'h7e7e, {8{8'h7d}}, 4'd8, 5'd0, 120'h0},
    '{1'b0, 32'h7e7e_7e7e, 16'h7e7e, {8{8'h7d}}, 4'd8, 5'd0, 120'h0},
    '{1'b0, 32'h7e7e_7e7e, 16'h7e7e, {8{8'h7d}}, 4'd8, 5'd0, 120'h0},
    '{1'b0, 32'h7e7e_7e7e, 16'h7e7e, {8{8'h7d}}, 4'd8, 5'd0, 120'h0},
    // A new buffer clears the saturated position.
    '{1'b1, 32'h00ff_00ff, 16'h0000, 64'h0, 4'd8, 5'd0, 120'h0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [7:0]       cfg_data_i = 8'h00;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             new_buffer_i = 1'b0;
  logic [31:0]      stamp_ms_i = 32'h0;
  logic [15:0]      channel_id_i = 16'h0;
  logic [63:0]      payload_i = 64'h0;
  logic [LEN_W-1:0] payload_len_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       out_byte_o;
  logic [7:0]       byte_index_o;
  logic             overflow_o;
  logic             last_o;

  // Predictor state: the start byte register and the buffer fill count.
  logic [7:0]        start_reg;
  logic [FILL_W-1:0] fill_count;
  framed_word_t      pkt_words[$];
  framed_word_t      framed_bytes[$];
  framed_word_t      want;

  int errors = 0;
  int words_seen = 0;
  int quiet_cycles = 0;
  int gap_max = 16;
  int stall_max = 16;
  int stall_left = 0;

  logger_packet_byte_stuffing_framer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .new_buffer_i  (new_buffer_i),
    .stamp_ms_i    (stamp_ms_i),
    .channel_id_i  (channel_id_i),
    .payload_i     (payload_i),
    .payload_len_i (payload_len_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_index_o  (byte_index_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  // Append one word at the current buffer position; the position saturates.
  task automatic put_byte(input logic [7:0] v);
    framed_word_t w;
    if (fill_count >= FILL_LIMIT) begin
      w.pos = 8'hff;
      w.ovf = 1'b1;
      fill_count = FILL_LIMIT;
    end else begin
      w.pos = fill_count[7:0];
      w.ovf = 1'b0;
      fill_count = fill_count + 1'b1;
    end
    w.byte_val = v;
    w.last_flag = 1'b0;
    pkt_words.push_back(w);
  endtask

  // Flag and escape bytes become an escape followed by the flipped byte.
  task automatic put_stuffed(input logic [7:0] v);
    if (v == FLAG_BYTE || v == ESC_BYTE) begin
      put_byte(ESC_BYTE);
      put_byte(v ^ ESC_XOR);
    end else begin
      put_byte(v);
    end
  endtask

  // Build the framed words of one packet into pkt_words.
  task automatic frame_packet(input packet_row_t p);
    int n;
    int k;
    pkt_words.delete();
    if (p.nb) begin
      fill_count = '0;
    end
    n = (p.len > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : int'(p.len);
    put_byte(start_reg);
    for (k = 3; k >= 0; k--) begin
      put_stuffed(p.stamp[8*k +: 8]);
    end
    for (k = 1; k >= 0; k--) begin
      put_stuffed(p.chan[8*k +: 8]);
    end
    for (k = n - 1; k >= 0; k--) begin
      put_stuffed(p.data[8*k +: 8]);
    end
    pkt_words[pkt_words.size() - 1].last_flag = 1'b1;
  endtask

  // Drive one packet after a random gap and record what it should produce.
  task automatic send_packet(input packet_row_t p);
    int gap;
    int k;
    framed_word_t w;
    gap = $urandom_range(0, gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    new_buffer_i  <= p.nb;
    stamp_ms_i    <= p.stamp;
    channel_id_i  <= p.chan;
    payload_i     <= p.data;
    payload_len_i <= p.len;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    frame_packet(p);
    if (p.n_typed != 0) begin
      for (k = 0; k < int'(p.n_typed); k++) begin
        w.byte_val = p.typed[119 - 8*k -: 8];
        w.pos = k[7:0];
        w.ovf = 1'b0;
        w.last_flag = (k == int'(p.n_typed) - 1);
        framed_bytes.push_back(w);
      end
    end else begin
      foreach (pkt_words[k]) framed_bytes.push_back(pkt_words[k]);
    end
  endtask

  task automatic write_start_byte(input logic [7:0] v);
    @(negedge clk_i);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    start_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (framed_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Random byte, biased toward the flag and escape bytes and their flipped forms when asked.
  function automatic logic [7:0] pick_byte(input bit heavy);
    if (!heavy) begin
      return 8'($urandom);
    end
    case ($urandom_range(0, 4))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return FLAG_BYTE ^ ESC_XOR;
      3: return ESC_BYTE ^ ESC_XOR;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic packet_row_t random_packet();
    packet_row_t p;
    bit heavy;
    int k;
    heavy = ($urandom_range(0, 1) == 1);
    p.nb = ($urandom_range(0, 11) == 0);
    for (k = 0; k < 4; k++) begin
      p.stamp[8*k +: 8] = pick_byte(heavy);
    end
    for (k = 0; k < 2; k++) begin
      p.chan[8*k +: 8] = pick_byte(heavy);
    end
    for (k = 0; k < 8; k++) begin
      p.data[8*k +: 8] = pick_byte(heavy);
    end
    if ($urandom_range(0, 9) < 9) begin
      p.len = LEN_W'($urandom_range(0, MAX_PAYLOAD_BYTES));
    end else begin
      p.len = LEN_W'($urandom_range(MAX_PAYLOAD_BYTES + 1, 15));
    end
    p.n_typed = '0;
    p.typed = '0;
    return p;
  endfunction

  // The receiver holds stall for a random count of cycles after each word.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted output word with the oldest expected word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (framed_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h index %0d", out_byte_o, byte_index_o));
      end else begin
        want = framed_bytes.pop_front();
        if (out_byte_o !== want.byte_val) begin
          report_mismatch($sformatf("word %0d out_byte %h, want %h",
                                    words_seen, out_byte_o, want.byte_val));
        end
        if (byte_index_o !== want.pos) begin
          report_mismatch($sformatf("word %0d byte_index %0d, want %0d",
                                    words_seen, byte_index_o, want.pos));
        end
        if (overflow_o !== want.ovf) begin
          report_mismatch($sformatf("word %0d overflow %b, want %b",
                                    words_seen, overflow_o, want.ovf));
        end
        if (last_o !== want.last_flag) begin
          report_mismatch($sformatf("word %0d last %b, want %b",
                                    words_seen, last_o, want.last_flag));
        end
      end
      words_seen++;
      stall_left = $urandom_range(0, stall_max);
    end
  end

  // Watchdog on cycles where no channel moves a word.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no progress, %0d words still expected", framed_bytes.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] cfg_val;
    int i;
    int ph;
    int n_rand;
    int mode;
    n_rand = 0;
    start_reg = START_RESET;
    fill_count = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed table with the reset start byte.
    for (i = 0; i < NUM_ROWS; i++) begin
      send_packet(DIRECTED[i]);
    end

    // Random phases, each under its own start byte, written once idle.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      wait_drained();
      case (ph)
        0: cfg_val = ESC_BYTE;
        1: cfg_val = 8'h00;
        2: cfg_val = 8'hff;
        4: cfg_val = START_RESET;
        6: cfg_val = FLAG_BYTE ^ ESC_XOR;
        default: cfg_val = 8'($urandom);
      endcase
      write_start_byte(cfg_val);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // Stretches of full pressure alternate with idling on either side.
        mode = (n_rand / 25) % 4;
        gap_max = (mode == 0 || mode == 3) ? 16 : 0;
        stall_max = (mode == 0 || mode == 2) ? 16 : 0;
        send_packet(random_packet());
        n_rand++;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/lbsf_pkg.sv
hdl/lbsf_front.sv
hdl/lbsf_fifo.sv
hdl/lbsf_back.sv
hdl/logger_packet_byte_stuffing_framer.sv
tb/logger_packet_byte_stuffing_framer_test.sv
